// ----- rtl/tlpq_pkg.sv -----
// shared constants, codes and types of the three-level priority queue
package tlpq_pkg;

  localparam int CAPACITY = 8;
  localparam int ID_WIDTH = 16;
  localparam int LEVELS   = 3;

  localparam int TASK_W  = 16;
  localparam int PRI_W   = 2;
  localparam int LVL_W   = 2;
  localparam int KEEP_W  = (ID_WIDTH < TASK_W) ? ID_WIDTH : TASK_W;
  localparam int PTR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int DEPTH   = LEVELS * CAPACITY;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPRI = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_ENQ_BAD = 2'd1,
    OP_DEQ     = 2'd2
  } op_t;

  typedef enum logic {
    BK_RUN   = 1'b0,
    BK_FETCH = 1'b1
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic [LVL_W-1:0]  lvl;
    logic [KEEP_W-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic             fetch;
    logic [CNT_W-1:0] total;
  } bk_stat_t;

endpackage

// ----- rtl/tlpq_front.sv -----
// front end: accepts input beats, decodes them and buffers commands in a two-entry queue
module tlpq_front import tlpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [TASK_W-1:0] in_task_id,
  input  logic [PRI_W-1:0]  in_priority_req,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       dec;

  always_comb begin
    dec.id  = in_task_id[KEEP_W-1:0];
    dec.lvl = LVL_W'(in_priority_req - 2'd1);
    if (in_mode) begin
      dec.op = OP_DEQ;
    end else if (in_priority_req == '0) begin
      dec.op = OP_ENQ_BAD;
    end else begin
      dec.op = OP_ENQ;
    end
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ----- rtl/tlpq_back.sv -----
// back end: per-level rings, counters, id store and the result register
module tlpq_back import tlpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TASK_W-1:0] out_task_id,
  output logic [1:0]        out_status,
  output bk_stat_t          stat
);

  bk_state_t         state_r, state_nxt;
  logic [PTR_W-1:0]  head_r [LEVELS];
  logic [PTR_W-1:0]  head_nxt [LEVELS];
  logic [PTR_W-1:0]  tail_r [LEVELS];
  logic [PTR_W-1:0]  tail_nxt [LEVELS];
  logic [CNT_W-1:0]  cnt_r [LEVELS];
  logic [CNT_W-1:0]  cnt_nxt [LEVELS];
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [TASK_W-1:0] out_task_id_r, out_task_id_nxt;
  status_t           out_status_r, out_status_nxt;

  logic [KEEP_W-1:0] store_r [DEPTH];
  logic [KEEP_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we, mem_re;

  logic              out_free, pop, full;
  logic              deq_hit;
  logic [LVL_W-1:0]  deq_lvl;
  logic [PTR_W-1:0]  enq_pos, deq_pos;

  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CAPACITY - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] ring_addr(input logic [LVL_W-1:0] lv,
                                                  input logic [PTR_W-1:0] pos);
    return ADDR_W'(ADDR_W'(lv) * ADDR_W'(CAPACITY) + ADDR_W'(pos));
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign full     = (total_r == CNT_W'(CAPACITY));

  // highest non-empty level wins
  always_comb begin
    deq_hit = 1'b1;
    deq_lvl = LVL_W'(2);
    if (cnt_r[2] != '0) begin
      deq_lvl = LVL_W'(2);
    end else if (cnt_r[1] != '0) begin
      deq_lvl = LVL_W'(1);
    end else if (cnt_r[0] != '0) begin
      deq_lvl = LVL_W'(0);
    end else begin
      deq_hit = 1'b0;
    end
  end

  always_comb begin
    case (deq_lvl)
      LVL_W'(0): deq_pos = head_r[0];
      LVL_W'(1): deq_pos = head_r[1];
      default:   deq_pos = head_r[2];
    endcase
    case (cmd.lvl)
      LVL_W'(0): enq_pos = tail_r[0];
      LVL_W'(1): enq_pos = tail_r[1];
      default:   enq_pos = tail_r[2];
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    cnt_nxt         = cnt_r;
    total_nxt       = total_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_task_id_nxt = out_task_id_r;
    out_status_nxt  = out_status_r;
    cmd_ready       = 1'b0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mem_addr        = ring_addr(cmd.lvl, enq_pos);
    pop             = 1'b0;

    unique case (state_r)
      BK_RUN: begin
        cmd_ready = out_free;
        pop       = cmd_valid && out_free;
        if (pop) begin
          out_task_id_nxt = '0;
          unique case (cmd.op)
            OP_DEQ: begin
              if (deq_hit) begin
                mem_re    = 1'b1;
                mem_addr  = ring_addr(deq_lvl, deq_pos);
                total_nxt = total_r - 1'b1;
                for (int l = 0; l < LEVELS; l++) begin
                  if (deq_lvl == LVL_W'(l)) begin
                    head_nxt[l] = ptr_advance(head_r[l]);
                    cnt_nxt[l]  = cnt_r[l] - 1'b1;
                  end
                end
                state_nxt = BK_FETCH;
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end
            end
            OP_ENQ: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                out_status_nxt = ST_OK;
                mem_we         = 1'b1;
                total_nxt      = total_r + 1'b1;
                for (int l = 0; l < LEVELS; l++) begin
                  if (cmd.lvl == LVL_W'(l)) begin
                    tail_nxt[l] = ptr_advance(tail_r[l]);
                    cnt_nxt[l]  = cnt_r[l] + 1'b1;
                  end
                end
              end
            end
            default: begin
              // full is reported ahead of a bad priority
              out_valid_nxt  = 1'b1;
              out_status_nxt = full ? ST_FULL : ST_BADPRI;
            end
          endcase
        end
      end
      BK_FETCH: begin
        // read data of the dequeue issued last cycle
        out_valid_nxt   = 1'b1;
        out_task_id_nxt = TASK_W'(rd_data_r);
        out_status_nxt  = ST_OK;
        state_nxt       = BK_RUN;
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l] <= '0;
        tail_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_task_id_r <= out_task_id_nxt;
    out_status_r  <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_r[mem_addr] <= cmd.id;
    end
    if (mem_re) begin
      rd_data_r <= store_r[mem_addr];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_task_id = out_task_id_r;
  assign out_status  = out_status_r;
  assign stat.fetch  = (state_r == BK_FETCH);
  assign stat.total  = total_r;

endmodule

// ----- rtl/three_level_priority_queue.sv -----
// top level of the three-level strict priority queue of task ids
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid/in_ready  | in_mode, in_task_id, in_priority_req
//   out     | output    | out_valid/out_ready| out_task_id, out_status
//
// an enqueue or a failed dequeue is answered directly by the back end, a successful
// dequeue passes the fetch state first: the id store has a registered read port
// a two-entry command queue lets input beats arrive while a result waits
// in_ready drops only when that queue holds two commands
// synchronous active-low reset empties all levels, the command queue and the result register
module three_level_priority_queue import tlpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [TASK_W-1:0] in_task_id,
  input  logic [PRI_W-1:0]  in_priority_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TASK_W-1:0] out_task_id,
  output logic [1:0]        out_status
);

  logic     cmd_valid;
  logic     cmd_ready;
  cmd_t     cmd;
  bk_stat_t stat;

  tlpq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_task_id      (in_task_id),
    .in_priority_req (in_priority_req),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd)
  );

  tlpq_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_task_id (out_task_id),
    .out_status  (out_status),
    .stat        (stat)
  );

`ifndef SYNTH
  // a command is taken only when the result register can take its beat
  a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready) |-> (!out_valid || out_ready))
    else $error("command taken while result register is blocked");

  // a dequeue read is followed by an ok result
  a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fetch |=> (out_valid && out_status == ST_OK))
    else $error("dequeue read did not produce an ok result");

  // no command is taken during the read cycle
  a_fetch_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fetch |-> !cmd_ready)
    else $error("command taken during dequeue read");

  // shared capacity is never exceeded
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.total <= CNT_W'(CAPACITY))
    else $error("total count above capacity");
`endif

endmodule
